// ===== design/swp_pkg.sv =====
// Shared types and constants of the stereo waveform plotter.
`default_nettype none
package swp_pkg;

  // Default screen geometry.
  localparam int unsigned SCREEN_WIDTH_DEF  = 160;
  localparam int unsigned SCREEN_HEIGHT_DEF = 80;

  // Maximum number of plot results caused by a single frame.
  localparam int unsigned MAX_RESULTS = 54;

  // Field and datapath widths.
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned FC_W       = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned STEP_W     = FC_W + FRAC_W;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned ROW_W      = 7;
  localparam int unsigned ROW_CALC_W = 10;

  // Fixed-point scaling of the upper sample half: divide by 32768.
  localparam int unsigned SCALE_SHIFT = 15;

  // Frame count register.
  localparam logic [FC_W-1:0] FRAME_COUNT_RST = 16'd160;
  localparam logic [FC_W-1:0] FRAME_COUNT_MIN = 16'd3;

  typedef struct packed {
    logic                       start_req;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } swp_in_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] left_row;
    logic             left_on;
    logic [ROW_W-1:0] right_row;
    logic             right_on;
    logic             screen_done;
    logic             last;
  } swp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE_L,
    ST_SCALE_R,
    ST_EMIT
  } swp_state_e;

endpackage
`default_nettype wire

// ===== design/swp_div.sv =====
// Step divider: frame count in 16.16 over a constant width by reciprocal multiplication.
`default_nettype none
module swp_div import swp_pkg::*; #(
  parameter int unsigned DIVISOR = SCREEN_WIDTH_DEF
) (
  input  wire logic [FC_W-1:0] fc_i,
  output logic [STEP_W-1:0]    quot_o
);

  // For every dividend below 2^32, floor(x / DIVISOR) equals
  // (x * RECIP) >> (STEP_W + SH) with RECIP = ceil(2^(STEP_W + SH) / DIVISOR)
  // and SH = ceil(log2(DIVISOR)). The dividend is fc * 2^16, so the low
  // FRAC_W bits of the shift fold into the frame count.
  localparam int unsigned SH      = $clog2(DIVISOR);
  localparam int unsigned RECIP_W = STEP_W + 2;
  localparam int unsigned PROD_W  = FRAC_W + SH + STEP_W;
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << (STEP_W + SH)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_64);

  logic [PROD_W-1:0] prod;

  assign prod   = PROD_W'(fc_i) * PROD_W'(RECIP);
  assign quot_o = prod[FRAC_W + SH +: STEP_W];

endmodule
`default_nettype wire

// ===== design/stereo_waveform_plotter.sv =====
// Top level of the stereo waveform plotter: sequencer, scaler and result register.
`default_nettype none
// The plotter takes one stereo frame per input transaction and spreads a buffer
// of frame_count frames over SCREEN_WIDTH columns with a 16.16 step of
// frame_count*65536/SCREEN_WIDTH. For every column that falls on the current
// frame it emits one result transaction with the mirrored column and the rows
// of the left and right points. A frame with start_req set restarts the
// buffer and recomputes the step in ST_DIV by multiplying the clamped frame
// count with a constant reciprocal of the width. Every other frame runs
// through the accept state, the two scale states on the shared multiplier
// (left row, then right row) and the emit phase, which gives one result per
// cycle while the output is not stalled and leaves at once when the frame
// plots nothing; a frame before the first start goes straight back to idle.
// Input stall is high while a frame is being worked on. Results sit in an
// output register, so the next frame is accepted while the last result still
// waits; a stalled output only holds up the emit phase. The frame_count
// register may be written at any time the block is idle and is sampled only
// by a start frame.
module stereo_waveform_plotter import swp_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [FC_W-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire swp_in_t         in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output swp_out_t             out_data_o
);

  localparam int unsigned SCALE   = SCREEN_HEIGHT / 4 - 2;
  localparam int unsigned SCALE_W = $clog2(SCALE + 1);
  localparam int unsigned PROD_W  = HALF_W + SCALE_W + 1;
  localparam int unsigned N_W     = $clog2(MAX_RESULTS + 1);

  localparam logic signed [SCALE_W:0]       SCALE_S = {1'b0, SCALE_W'(SCALE)};
  localparam logic signed [ROW_CALC_W-1:0]  CTR_L   = ROW_CALC_W'(SCREEN_HEIGHT / 4);
  localparam logic signed [ROW_CALC_W-1:0]  CTR_R   = ROW_CALC_W'((3 * SCREEN_HEIGHT) / 4);
  localparam logic [COL_W-1:0]              COL_LAST = COL_W'(SCREEN_WIDTH - 1);

  swp_state_e state_q, state_d;

  logic [FC_W-1:0]   fc_q;
  logic [COL_W-1:0]  col_q;
  logic [STEP_W-1:0] pos_q;
  logic [STEP_W-1:0] step_q;
  logic [FC_W-1:0]   frame_q;
  logic [N_W-1:0]    n_q;

  logic signed [HALF_W-1:0] lhi_q, rhi_q;
  logic [ROW_W-1:0]         lrow_q, rrow_q;
  logic                     lon_q, ron_q;

  swp_out_t out_q;
  logic     out_valid_q;

  logic in_acc, out_free;
  logic div_start, mul_right, emit, frame_inc;
  logic [STEP_W-1:0] quot;
  logic [FC_W-1:0]   fc_cl;

  logic hit, hit_nx;
  logic [STEP_W-1:0] pos_nx;
  logic [COL_W:0]    col_nx;
  logic [N_W-1:0]    n_nx;

  logic signed [HALF_W-1:0]     mul_a;
  logic signed [PROD_W-1:0]     prod, prod_sh;
  logic signed [ROW_CALC_W-1:0] centre, y;
  logic                         y_on;
  logic [ROW_W-1:0]             y_row;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // Step computation: frame_count (clamped to at least 3) in 16.16 over the width.
  assign fc_cl = (fc_q < FRAME_COUNT_MIN) ? FRAME_COUNT_MIN : fc_q;

  swp_div #(
    .DIVISOR (SCREEN_WIDTH)
  ) u_div (
    .fc_i   (fc_cl),
    .quot_o (quot)
  );

  // Column match for the current and for the following column.
  always_comb begin
    pos_nx = pos_q + step_q;
    col_nx = {1'b0, col_q} + 1'b1;
    n_nx   = n_q + 1'b1;
    hit    = (n_q < N_W'(MAX_RESULTS)) && (col_q < COL_W'(SCREEN_WIDTH)) &&
             (pos_q[STEP_W-1 -: FC_W] == frame_q);
    hit_nx = (n_nx < N_W'(MAX_RESULTS)) && (col_nx < (COL_W + 1)'(SCREEN_WIDTH)) &&
             (pos_nx[STEP_W-1 -: FC_W] == frame_q);
  end

  // One multiplier serves both channels; floor scaling is an arithmetic shift.
  always_comb begin
    mul_a   = mul_right ? rhi_q : lhi_q;
    centre  = mul_right ? CTR_R : CTR_L;
    prod    = mul_a * SCALE_S;
    prod_sh = prod >>> SCALE_SHIFT;
    y       = centre + $signed(prod_sh[ROW_CALC_W-1:0]);
    y_on    = !y[ROW_CALC_W-1] &&
              (y[ROW_CALC_W-2:0] < (ROW_CALC_W - 1)'(SCREEN_HEIGHT));
    y_row   = y_on ? y[ROW_W-1:0] : '0;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.start_req) begin
            state_d = ST_DIV;
          end else if (step_q != '0) begin
            state_d = ST_SCALE_L;
          end
        end
      end
      ST_DIV: begin
        state_d = ST_SCALE_L;
      end
      ST_SCALE_L: begin
        state_d = ST_SCALE_R;
      end
      ST_SCALE_R: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!hit || (out_free && !hit_nx)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    mul_right  = 1'b0;
    emit       = 1'b0;
    frame_inc  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_acc & in_data_i.start_req;
        frame_inc  = in_acc & ~in_data_i.start_req & (step_q == '0);
      end
      ST_DIV: begin
      end
      ST_SCALE_L: begin
      end
      ST_SCALE_R: begin
        mul_right = 1'b1;
      end
      ST_EMIT: begin
        emit      = hit & out_free;
        frame_inc = ~hit | (out_free & ~hit_nx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fc_q        <= FRAME_COUNT_RST;
      col_q       <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      frame_q     <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        fc_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        n_q <= '0;
      end
      if (div_start) begin
        col_q   <= '0;
        pos_q   <= '0;
        frame_q <= '0;
      end
      if (state_q == ST_DIV) begin
        step_q <= quot;
      end
      if (emit) begin
        pos_q <= pos_nx;
        col_q <= col_nx[COL_W-1:0];
        n_q   <= n_nx;
      end
      if (frame_inc && frame_q != '1) begin
        frame_q <= frame_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lhi_q <= in_data_i.left_sample[SAMPLE_W-1 -: HALF_W];
      rhi_q <= in_data_i.right_sample[SAMPLE_W-1 -: HALF_W];
    end
    if (state_q == ST_SCALE_L) begin
      lrow_q <= y_row;
      lon_q  <= y_on;
    end
    if (state_q == ST_SCALE_R) begin
      rrow_q <= y_row;
      ron_q  <= y_on;
    end
    if (emit) begin
      out_q.column      <= COL_LAST - col_q;
      out_q.left_row    <= lrow_q;
      out_q.left_on     <= lon_q;
      out_q.right_row   <= rrow_q;
      out_q.right_on    <= ron_q;
      out_q.screen_done <= col_q == COL_LAST;
      out_q.last        <= ~hit_nx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_result_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> step_q != '0)
    else $error("result issued before any buffer was started");

  a_column_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.column <= COL_LAST)
    else $error("result column lies beyond the screen");

  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= N_W'(MAX_RESULTS))
    else $error("too many results for one frame");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !hit_nx) |=> (state_q == ST_IDLE && out_valid_o && out_data_o.last))
    else $error("last result did not end the frame");
`endif

endmodule
`default_nettype wire

// ===== test/swp_plot_checker.sv =====
// Plot checker: watches the plotter's channels, predicts every plot result and compares.
`default_nettype none
module swp_plot_checker import swp_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [FC_W-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  input  wire logic            in_stall_i,
  input  wire swp_in_t         in_data_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_stall_i,
  input  wire swp_out_t        out_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  // Shadow copy of the register and of the plotter's sweep state.
  logic [FC_W-1:0]   frame_count_q;
  logic [COL_W-1:0]  column_q;
  logic [STEP_W-1:0] position_q;
  logic [STEP_W-1:0] step_q;
  logic [FC_W-1:0]   frame_num_q;

  swp_out_t plots_due[$];
  int       errors;

  // Row of one channel point: upper sample half scaled by (H/4 - 2)/32768, floored.
  function automatic int channel_row(logic [SAMPLE_W-1:0] sample, int centre);
    logic signed [HALF_W-1:0] upper;
    int                       scaled;
    upper  = sample[SAMPLE_W-1 -: HALF_W];
    scaled = int'(upper) * (int'(SCREEN_HEIGHT / 4) - 2);
    return centre + (scaled >>> SCALE_SHIFT);
  endfunction

  task automatic plot_frame(swp_in_t frame);
    logic [FC_W-1:0] fc_eff;
    int              left_row;
    int              right_row;
    logic            left_on;
    logic            right_on;
    logic            more;
    int              n;
    swp_out_t        plot;
    if (frame.start_req) begin
      fc_eff      = (frame_count_q < FRAME_COUNT_MIN) ? FRAME_COUNT_MIN : frame_count_q;
      step_q      = {fc_eff, {FRAC_W{1'b0}}} / SCREEN_WIDTH;
      column_q    = '0;
      position_q  = '0;
      frame_num_q = '0;
    end
    // A zero step means no buffer has been started yet.
    if (step_q != '0) begin
      left_row  = channel_row(frame.left_sample, int'(SCREEN_HEIGHT / 4));
      right_row = channel_row(frame.right_sample, int'((3 * SCREEN_HEIGHT) / 4));
      left_on   = left_row >= 0 && left_row < int'(SCREEN_HEIGHT);
      right_on  = right_row >= 0 && right_row < int'(SCREEN_HEIGHT);
      n    = 0;
      more = column_q < SCREEN_WIDTH && position_q[STEP_W-1:FRAC_W] == frame_num_q;
      while (more) begin
        plot.column      = COL_W'(SCREEN_WIDTH - 1 - column_q);
        plot.left_row    = left_on ? ROW_W'(left_row) : '0;
        plot.left_on     = left_on;
        plot.right_row   = right_on ? ROW_W'(right_row) : '0;
        plot.right_on    = right_on;
        plot.screen_done = (column_q == SCREEN_WIDTH - 1);
        position_q       = position_q + step_q;
        column_q         = column_q + 1'b1;
        n++;
        more = n < MAX_RESULTS && column_q < SCREEN_WIDTH &&
               position_q[STEP_W-1:FRAC_W] == frame_num_q;
        plot.last = !more;
        plots_due.push_back(plot);
      end
    end
    if (frame_num_q != '1) begin
      frame_num_q = frame_num_q + 1'b1;
    end
  endtask

  task automatic report(string field, int want, int got);
    $error("plot field %s: expected %0d, actual %0d", field, want, got);
    errors++;
  endtask

  task automatic check_plot(swp_out_t got);
    swp_out_t want;
    if (plots_due.size() == 0) begin
      $error("plot result at column %0d with none expected", got.column);
      errors++;
    end else begin
      want = plots_due.pop_front();
      if (got.column !== want.column) report("column", want.column, got.column);
      if (got.left_row !== want.left_row) report("left_row", want.left_row, got.left_row);
      if (got.left_on !== want.left_on) report("left_on", want.left_on, got.left_on);
      if (got.right_row !== want.right_row) report("right_row", want.right_row, got.right_row);
      if (got.right_on !== want.right_on) report("right_on", want.right_on, got.right_on);
      if (got.screen_done !== want.screen_done) begin
        report("screen_done", want.screen_done, got.screen_done);
      end
      if (got.last !== want.last) report("last", want.last, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q = FRAME_COUNT_RST;
      column_q      = '0;
      position_q    = '0;
      step_q        = '0;
      frame_num_q   = '0;
      errors        = 0;
      plots_due.delete();
    end else begin
      if (cfg_we_i) begin
        frame_count_q = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        check_plot(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        plot_frame(in_data_i);
      end
    end
    mismatch_count_o = errors;
    pending_o        = plots_due.size();
  end

endmodule
`default_nettype wire

// ===== test/stereo_waveform_plotter_tb.sv =====
// Testbench top of the stereo waveform plotter: clock, reset, stimulus and verdict.
`default_nettype none
module stereo_waveform_plotter_tb;
  import swp_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [FC_W-1:0] cfg_wdata;
  logic            in_valid;
  logic            in_stall;
  swp_in_t         in_data;
  logic            out_valid;
  logic            out_stall;
  swp_out_t        out_data;

  int mismatches;
  int plots_pending;

  // Random idling on the sender side (gaps) and on the receiver side (stall bursts).
  bit gaps_on         = 1'b0;
  bit stall_bursts_on = 1'b0;

  always #6 clk_i = ~clk_i;

  stereo_waveform_plotter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // The checker sits beside the block, sees the same pins and keeps its own prediction.
  swp_plot_checker i_plot_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .pending_o        (plots_pending)
  );

  // Mostly random samples, with the corners of the upper half mixed in often so
  // that the extreme rows show up in every phase.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return {16'h8000, 16'($urandom())};
      5:       return {16'h7FFF, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // Drives one frame transaction and holds it until the plotter takes it. All
  // inputs change at the falling edge; acceptance is judged on the values that
  // were present at the rising edge. Valid stays high into the next item unless
  // a gap is drawn, so it is never dropped and raised in the same step.
  task automatic send_frame(logic start, logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid             = 1'b1;
    in_data.start_req    = start;
    in_data.left_sample  = left;
    in_data.right_sample = right;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Brings the plotter to rest: every predicted plot has arrived, and a frame
  // that plots nothing has had time to drain before the register is touched.
  task automatic drain();
    in_valid = 1'b0;
    while (plots_pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_frame_count(logic [FC_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // The receiver stalls in random bursts whenever bursts are on.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_bursts_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall = 1'b0;
      end
    end
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [FC_W-1:0] frame_count;
    int              frames;
    int              sent;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    gaps_on         = 1'b1;
    stall_bursts_on = 1'b1;

    // Frames before any start carry no buffer, so they must plot nothing.
    send_frame(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_frame(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);

    // Start with the reset frame count of 160: one column per frame, with the
    // most negative and most positive samples on both channels.
    send_frame(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_frame(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_frame(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_frame(1'b0, 32'h0000_FFFF, 32'hFFFF_0000);
    drain();

    // A frame count of zero is raised to the minimum of three. That gives the
    // densest sweep: 54 columns on the first frame, the whole screen after
    // three frames, and nothing at all on the frame after that.
    write_frame_count(16'd0);
    send_frame(1'b1, pick_sample(), pick_sample());
    send_frame(1'b0, pick_sample(), pick_sample());
    send_frame(1'b0, pick_sample(), pick_sample());
    send_frame(1'b0, pick_sample(), pick_sample());
    send_frame(1'b0, pick_sample(), pick_sample());
    drain();

    // The largest frame count: column 0 on the start frame, then a long wait.
    write_frame_count(16'hFFFF);
    send_frame(1'b1, pick_sample(), pick_sample());
    send_frame(1'b0, pick_sample(), pick_sample());
    drain();

    // Random phases. Each one writes a new frame count and then sends a whole
    // buffer with random samples, running a few frames past the end of the
    // screen. Now and then a start lands in the middle of a buffer and
    // restarts the sweep. Some phases run with no idling on either side.
    sent = 0;
    while (sent < 420) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:  frame_count = 16'($urandom_range(0, 2));
        5, 6, 7:        frame_count = 16'($urandom_range(100, 200));
        default:        frame_count = 16'($urandom_range(3, 24));
      endcase
      gaps_on         = $urandom_range(0, 3) != 0;
      stall_bursts_on = $urandom_range(0, 3) != 0;
      write_frame_count(frame_count);
      frames = ((frame_count < FRAME_COUNT_MIN) ? FRAME_COUNT_MIN : frame_count) +
               $urandom_range(1, 4);
      for (int k = 0; k < frames && sent < 420; k++) begin
        send_frame(k == 0 || $urandom_range(0, 59) == 0, pick_sample(), pick_sample());
        sent++;
      end
      drain();
    end

    // Last part, with no idling: one buffer of 40 frames, run a few frames
    // past the end of the screen.
    gaps_on         = 1'b0;
    stall_bursts_on = 1'b0;
    write_frame_count(16'd40);
    send_frame(1'b1, pick_sample(), pick_sample());
    for (int k = 0; k < 44; k++) begin
      send_frame(1'b0, pick_sample(), pick_sample());
    end
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
